// ===== src/pwm_period_duty_calculator_assert.svh =====
// ----------------------------------------------------------------------------
// PWM period and duty calculator: assertion macros
// Shared macros for the concurrent checks on the calculator's ports.
// ----------------------------------------------------------------------------
`ifndef PWM_PERIOD_DUTY_CALCULATOR_ASSERT_SVH
`define PWM_PERIOD_DUTY_CALCULATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PWMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwm calculator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PWMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwm calculator check failed");

`endif

// ===== src/pwmc_pkg.sv =====
// ----------------------------------------------------------------------------
// PWM period and duty calculator package
// Clock constants, field widths, prescale codes and inter-stage structs.
// ----------------------------------------------------------------------------
package pwmc_pkg;

    // Timer input clock in hertz.
    localparam int unsigned CLOCK_HZ = 4000000;

    // floor(CLOCK_HZ / (4 * s * half)) equals floor(floor(CLOCK_HZ / 4) / half) / s,
    // so one division by the halved frequency serves all three prescalers.
    localparam int unsigned NUM_INT = CLOCK_HZ / 4;
    localparam int          NUM_W   = $clog2(NUM_INT + 1);
    localparam logic [NUM_W-1:0] NUM_VAL = NUM_W'(NUM_INT);

    // Field widths.
    localparam int TONE_W   = 15;
    localparam int HALF_W   = TONE_W - 1;
    localparam int Q_W      = 9;   // selected quotient, 1 to 256
    localparam int PERIOD_W = 8;
    localparam int DUTY_W   = 10;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // Largest quotient that fits the 8-bit period register.
    localparam logic [Q_W-1:0] Q_MAX = 9'd256;

    // Division by five through a reciprocal: floor(x / 5) = (x * 52429) >> 18
    // for any x below 2^16.
    localparam int DUTY_X_W     = Q_W + 4;
    localparam int RECIP_W      = 16;
    localparam int PROD_W       = DUTY_X_W + RECIP_W;
    localparam int DUTY_SHIFT   = 18;
    localparam logic [RECIP_W-1:0] RECIP5 = 16'd52429;

    // Prescale codes as written to the timer.
    typedef enum logic [1:0] {
        PRESCALE_DIV1  = 2'd0,
        PRESCALE_DIV4  = 2'd1,
        PRESCALE_DIV16 = 2'd2
    } prescale_t;

    // Divider result handed to the selection stage.
    typedef struct packed {
        logic             valid;
        logic             nonzero;
        logic [NUM_W-1:0] quo;
    } div_out_t;

    // One finished result.
    typedef struct packed {
        logic                ok;
        logic [1:0]          duty_low;
        logic [7:0]          duty_high;
        logic [1:0]          prescale_code;
        logic [PERIOD_W-1:0] period_count;
    } result_t;

endpackage

// ===== src/pwm_period_duty_calculator.sv =====
// ----------------------------------------------------------------------------
// PWM period and duty calculator
// Turns a tone frequency request into timer period, prescale and duty values.
// ----------------------------------------------------------------------------
// Usage:
// A request on the s_axis channel carries tone_hz in tdata[14:0]. The block
// halves it, divides CLOCK_HZ / 4 by the result and takes the first of the
// prescalers 1, 4 and 16 that gives a period of at most 255. The m_axis
// channel returns one result per request, in request order.
// A request passes 20 divider stages, one quotient bit each, then one
// selection stage and the output register, which takes the product of the
// duty multiplier. A new request is taken every cycle unless a result is
// stalled. The whole pipeline advances together: when the receiver holds
// m_axis_tready low with a result waiting, every stage holds and
// s_axis_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits, so the pipeline starts empty and ready.
// A halved frequency of zero, or no fitting prescaler, gives ok = 0 with
// every other field zero.
// ----------------------------------------------------------------------------
module pwm_period_duty_calculator
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [pwmc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [14:0] tone_hz
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] period_count, [9:8] prescale_code, [17:10] duty_high,
    // [19:18] duty_low, [20] ok, rest zero
    output logic [pwmc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import pwmc_pkg::*;

    logic              en;
    logic [HALF_W-1:0] half;
    div_out_t          div_res;
    result_t           res;

    // Pipeline advances unless a finished result waits with m_axis_tready low.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Halve the requested frequency.
    assign half = s_axis_tdata[TONE_W-1:1];

    pwmc_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .half     (half),
        .res      (div_res)
    );

    pwmc_select u_sel
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .div_in    (div_res),
        .out_valid (m_axis_tvalid),
        .out_res   (res)
    );

    // Pack the result fields from the lowest bit up.
    assign m_axis_tdata = {3'b000, res};

endmodule

// ===== src/pwmc_divider.sv =====
// ----------------------------------------------------------------------------
// PWM calculator divider
// Pipelined restoring divider of the constant CLOCK_HZ / 4 by the halved
// frequency, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module pwmc_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [pwmc_pkg::HALF_W-1:0]   half,
    output pwmc_pkg::div_out_t            res
);
    import pwmc_pkg::*;

    logic [HALF_W-1:0] rem_reg [0:NUM_W-1];
    logic [NUM_W-1:0]  quo_reg [0:NUM_W-1];
    logic [HALF_W-1:0] den_reg [0:NUM_W-1];
    logic              vld_reg [0:NUM_W-1];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [HALF_W-1:0] rem_in;
        logic [NUM_W-1:0]  quo_in;
        logic [HALF_W-1:0] den_in;
        logic              vld_in;
        logic [HALF_W:0]   trial;
        logic [HALF_W:0]   diff;
        logic              take;

        // Stage inputs come from the request or from the previous stage.
        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
            assign den_in = half;
            assign vld_in = in_valid;
        end
        else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign den_in = den_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        // Bring down the next numerator bit and try one subtraction.
        assign trial = {rem_in, NUM_VAL[NUM_W-1-k]};
        assign diff  = trial - {1'b0, den_in};
        assign take  = (trial >= {1'b0, den_in});

        // Valid bit travels with the data.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        // Partial remainder and quotient.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? diff[HALF_W-1:0] : trial[HALF_W-1:0];
                quo_reg[k] <= {quo_in[NUM_W-2:0], take};
                den_reg[k] <= den_in;
            end
        end
    end

    // A zero divisor yields all ones; the flag marks it for rejection.
    assign res.valid   = vld_reg[NUM_W-1];
    assign res.nonzero = |den_reg[NUM_W-1];
    assign res.quo     = quo_reg[NUM_W-1] | {{(NUM_W-1){1'b0}}, 1'b0 & rem_reg[NUM_W-1][0]};

endmodule

// ===== src/pwmc_select.sv =====
// ----------------------------------------------------------------------------
// PWM calculator prescaler selection
// Picks the first prescaler whose quotient fits, then forms the period and
// the duty (16 * q / 5) in the output register.
// ----------------------------------------------------------------------------
module pwmc_select
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  pwmc_pkg::div_out_t div_in,
    output logic               out_valid,
    output pwmc_pkg::result_t  out_res
);
    import pwmc_pkg::*;

    logic            sel_vld_reg;
    logic            sel_ok_reg;
    prescale_t       sel_code_reg;
    logic [Q_W-1:0]  sel_q_reg;

    logic            sel_ok_next;
    prescale_t       sel_code_next;
    logic [Q_W-1:0]  sel_q_next;

    logic                out_vld_reg;
    result_t             out_res_reg;
    result_t             out_res_next;
    logic [DUTY_X_W-1:0] duty_x;
    logic [PROD_W-1:0]   duty_prod;
    logic [DUTY_W-1:0]   duty;

    // Prescalers 1, 4 and 16 in order; a quotient of zero never fits.
    always_comb
    begin
        sel_ok_next   = 1'b1;
        sel_code_next = PRESCALE_DIV1;
        sel_q_next    = div_in.quo[Q_W-1:0];
        priority if (!div_in.nonzero || div_in.quo == '0)
        begin
            sel_ok_next = 1'b0;
        end
        else if (div_in.quo <= NUM_W'(Q_MAX))
        begin
            sel_code_next = PRESCALE_DIV1;
            sel_q_next    = div_in.quo[Q_W-1:0];
        end
        else if ((div_in.quo >> 2) <= NUM_W'(Q_MAX))
        begin
            sel_code_next = PRESCALE_DIV4;
            sel_q_next    = div_in.quo[Q_W+1:2];
        end
        else if ((div_in.quo >> 4) <= NUM_W'(Q_MAX))
        begin
            sel_code_next = PRESCALE_DIV16;
            sel_q_next    = div_in.quo[Q_W+3:4];
        end
        else
        begin
            sel_ok_next = 1'b0;
        end
    end

    // Selection stage and output stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            sel_vld_reg <= div_in.valid;
            out_vld_reg <= sel_vld_reg;
        end
    end

    // Selection stage payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_ok_reg   <= sel_ok_next;
            sel_code_reg <= sel_code_next;
            sel_q_reg    <= sel_q_next;
        end
    end

    // Duty is floor(16 * q / 5) through the reciprocal of five.
    assign duty_x    = {sel_q_reg, 4'b0000};
    assign duty_prod = PROD_W'(duty_x) * PROD_W'(RECIP5);
    assign duty      = duty_prod[DUTY_SHIFT+DUTY_W-1:DUTY_SHIFT];

    // Failed requests report all fields as zero.
    always_comb
    begin
        out_res_next = '0;
        if (sel_ok_reg)
        begin
            out_res_next.ok            = 1'b1;
            out_res_next.period_count  = PERIOD_W'(sel_q_reg - Q_W'(1));
            out_res_next.prescale_code = sel_code_reg;
            out_res_next.duty_high     = duty[DUTY_W-1:2];
            out_res_next.duty_low      = duty[1:0];
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_res_reg <= out_res_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_res   = out_res_reg;

endmodule

// ===== src/pwmc_checker.sv =====
// ----------------------------------------------------------------------------
// PWM calculator port checker
// Concurrent checks on the calculator's ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "pwm_period_duty_calculator_assert.svh"

module pwmc_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic [pwmc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [pwmc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import pwmc_pkg::*;

    // A request on offer carries known data.
    `PWMC_ASSERT_NOW(a_in_known, clk, rst_n, s_axis_tvalid, !$isunknown(s_axis_tdata))

    // A stalled result stays put with its data.
    `PWMC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // With no result waiting, the pipeline must take requests.
    `PWMC_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !m_axis_tvalid, s_axis_tready)

    // A failed result carries zeros in every field.
    `PWMC_ASSERT_NOW(a_fail_zero, clk, rst_n, m_axis_tvalid && !m_axis_tdata[20], m_axis_tdata == '0)

    // A good result has a defined prescale code and a duty below 820.
    `PWMC_ASSERT_NOW(a_ok_range, clk, rst_n, m_axis_tvalid && m_axis_tdata[20], m_axis_tdata[9:8] != 2'd3 && m_axis_tdata[17:10] <= 8'd204)

endmodule

bind pwm_period_duty_calculator pwmc_checker u_pwmc_checker (.*);
